// ----- hdl/stok_pkg.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer package
// Shared types, token kinds and constants for the tokenizer block.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int KEYWORD_CHARS_DEF     = 8;
  localparam int MAX_COMMENT_DEPTH_DEF = 255;

  localparam logic [4:0] K_IF       = 5'd0;
  localparam logic [4:0] K_ELSE     = 5'd1;
  localparam logic [4:0] K_WHILE    = 5'd2;
  localparam logic [4:0] K_FN       = 5'd3;
  localparam logic [4:0] K_VAR      = 5'd4;
  localparam logic [4:0] K_RETURN   = 5'd5;
  localparam logic [4:0] K_BREAK    = 5'd6;
  localparam logic [4:0] K_CONTINUE = 5'd7;
  localparam logic [4:0] K_BRACE    = 5'd8;
  localparam logic [4:0] K_PAREN    = 5'd9;
  localparam logic [4:0] K_ARROW    = 5'd10;
  localparam logic [4:0] K_COLON    = 5'd11;
  localparam logic [4:0] K_SEMI     = 5'd12;
  localparam logic [4:0] K_OPER     = 5'd13;
  localparam logic [4:0] K_IDENT    = 5'd14;
  localparam logic [4:0] K_INT      = 5'd15;
  localparam logic [4:0] K_INVALID  = 5'd16;
  localparam logic [4:0] K_EOF      = 5'd17;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [31:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } out_item_t;

  // Results of one byte: up to three tokens.
  typedef struct packed {
    logic [1:0]      count;
    out_item_t [2:0] tok;
  } bundle_t;

  typedef enum logic [7:0] {
    M_IDLE        = 8'b0000_0001,
    M_IDENT       = 8'b0000_0010,
    M_INT         = 8'b0000_0100,
    M_OPFIRST     = 8'b0000_1000,
    M_LINE        = 8'b0001_0000,
    M_BLOCK       = 8'b0010_0000,
    M_BLOCK_STAR  = 8'b0100_0000,
    M_BLOCK_SLASH = 8'b1000_0000
  } mode_t;

endpackage

// ----- hdl/source_tokenizer_nested_comments.sv -----
// A token is registered in the bundle queue before it leaves.
// Throughput: one byte per cycle while the queue has room and each byte yields
// at most one token; a byte yielding k tokens occupies the output for k beats.
// A four-entry bundle queue between scanner and output sets the slack.
// Synchronous active-low reset returns the scanner to line 1, column 1.
// ----------------------------------------------------------------------------
// Source tokenizer with nested comments
// Longest-match lexer that emits one token per output beat.
// ----------------------------------------------------------------------------
module source_tokenizer_nested_comments #(
  parameter int KEYWORD_CHARS     = stok_pkg::KEYWORD_CHARS_DEF,
  parameter int MAX_COMMENT_DEPTH = stok_pkg::MAX_COMMENT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stok_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stok_pkg::out_item_t out_data
);

  logic              bq_valid, bq_full;
  stok_pkg::bundle_t bq_data;

  stok_front #(
    .KEYWORD_CHARS    (KEYWORD_CHARS),
    .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .bq_valid, .bq_full, .bq_data
  );

  stok_back u_back (
    .clk, .rst_n, .bq_valid, .bq_full, .bq_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ----- hdl/stok_front.sv -----
// ----------------------------------------------------------------------------
// Tokenizer front end
// Scans one byte per cycle unless stalled; bundles the tokens it completes.
// ----------------------------------------------------------------------------
module stok_front #(
  parameter int KEYWORD_CHARS     = stok_pkg::KEYWORD_CHARS_DEF,
  parameter int MAX_COMMENT_DEPTH = stok_pkg::MAX_COMMENT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stok_pkg::in_item_t in_data,
  output logic               bq_valid,
  input  logic               bq_full,
  output stok_pkg::bundle_t  bq_data
);

  localparam int DW = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [DW-1:0] DMAX = DW'(MAX_COMMENT_DEPTH);
  localparam logic [15:0] KC = 16'(KEYWORD_CHARS);

  stok_pkg::mode_t mode_r, mode_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [KEYWORD_CHARS-1:0][7:0] pre_r, pre_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic [31:0]     line_r, line_nxt;
  logic [15:0]     col_r, col_nxt;
  logic [31:0]     so_r, so_nxt;
  logic [31:0]     sl_r, sl_nxt;
  logic [15:0]     sc_r, sc_nxt;

  logic [7:0] b;
  logic       go, alpha, digit, space, used;
  logic [4:0] ikind;
  stok_pkg::bundle_t bd;

  assign in_stall = bq_full;
  assign go       = in_valid && !bq_full;
  assign b        = in_data.src_byte;
  assign alpha    = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  assign digit    = b >= "0" && b <= "9";
  assign space    = b == 8'd32 || (b >= 8'd9 && b <= 8'd13);

  function automatic logic kw_eq(input logic [KEYWORD_CHARS-1:0][7:0] p,
                                 input logic [63:0] txt, input int n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i < n && p[i] != txt[8*i +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [KEYWORD_CHARS-1:0][7:0] p,
                                         input logic [15:0] len);
    logic [4:0] k;
    k = stok_pkg::K_IDENT;
    if (len <= KC) begin
      if (len == 16'd8 && kw_eq(p, "eunitnoc", 8)) k = stok_pkg::K_CONTINUE;
      if (len == 16'd5 && kw_eq(p, {24'd0, "kaerb"}, 5)) k = stok_pkg::K_BREAK;
      if (len == 16'd6 && kw_eq(p, {16'd0, "nruter"}, 6)) k = stok_pkg::K_RETURN;
      if (len == 16'd3 && kw_eq(p, {40'd0, "rav"}, 3)) k = stok_pkg::K_VAR;
      if (len == 16'd2 && kw_eq(p, {48'd0, "nf"}, 2)) k = stok_pkg::K_FN;
      if (len == 16'd5 && kw_eq(p, {24'd0, "elihw"}, 5)) k = stok_pkg::K_WHILE;
      if (len == 16'd4 && kw_eq(p, {32'd0, "esle"}, 4)) k = stok_pkg::K_ELSE;
      if (len == 16'd2 && kw_eq(p, {48'd0, "fi"}, 2)) k = stok_pkg::K_IF;
    end
    return k;
  endfunction

  assign ikind = kw_kind(pre_r, len_r);

  always_comb begin
    logic [1:0] n;
    logic [4:0] fk;
    logic       fl;
    stok_pkg::out_item_t t;
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    first_nxt = first_r;
    pre_nxt   = pre_r;
    len_nxt   = len_r;
    so_nxt    = so_r;
    sl_nxt    = sl_r;
    sc_nxt    = sc_r;
    used      = 1'b0;
    n         = 2'd0;
    bd        = '0;
    t         = '0;
    fk        = '0;
    fl        = 1'b0;
    t.token_start   = so_r;
    t.line_number   = sl_r;
    t.column_number = sc_r;
    t.token_length  = len_r;
    unique case (mode_r)
      stok_pkg::M_IDENT: begin
        if (alpha || digit) begin
          for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (len_r == 16'(i)) pre_nxt[i] = b;
          end
          if (len_r != 16'hFFFF) len_nxt = len_r + 16'd1;
          used = 1'b1;
        end else begin
          t.token_kind = ikind;
          bd.tok[0] = t;
          n = 2'd1;
          mode_nxt = stok_pkg::M_IDLE;
        end
      end
      stok_pkg::M_INT: begin
        if (digit) begin
          if (len_r != 16'hFFFF) len_nxt = len_r + 16'd1;
          used = 1'b1;
        end else begin
          t.token_kind = stok_pkg::K_INT;
          bd.tok[0] = t;
          n = 2'd1;
          mode_nxt = stok_pkg::M_IDLE;
        end
      end
      stok_pkg::M_OPFIRST: begin
        mode_nxt = stok_pkg::M_IDLE;
        used = 1'b1;
        t.token_length = 16'd2;
        if (first_r == "-" && b == ">") begin
          t.token_kind = stok_pkg::K_ARROW;
          bd.tok[0] = t;
          n = 2'd1;
        end else if ((first_r == "+" && b == "+") || (first_r == "-" && b == "-")
                     || b == "=") begin
          t.token_kind = stok_pkg::K_OPER;
          bd.tok[0] = t;
          n = 2'd1;
        end else if (first_r == "/" && b == "/") begin
          mode_nxt = stok_pkg::M_LINE;
        end else if (first_r == "/" && b == "*") begin
          mode_nxt = stok_pkg::M_BLOCK;
          depth_nxt = DW'(1);
        end else begin
          t.token_kind = stok_pkg::K_OPER;
          t.token_length = 16'd1;
          bd.tok[0] = t;
          n = 2'd1;
          used = 1'b0;
        end
      end
      stok_pkg::M_LINE: begin
        if (b == 8'd10) mode_nxt = stok_pkg::M_IDLE;
        used = 1'b1;
      end
      stok_pkg::M_BLOCK_STAR: begin
        used = 1'b1;
        if (b == "/") begin
          depth_nxt = (depth_r != '0) ? depth_r - DW'(1) : depth_r;
          mode_nxt = (depth_nxt == '0) ? stok_pkg::M_IDLE : stok_pkg::M_BLOCK;
        end else if (b == "*") begin
          mode_nxt = stok_pkg::M_BLOCK_STAR;
        end else begin
          mode_nxt = stok_pkg::M_BLOCK;
        end
      end
      stok_pkg::M_BLOCK_SLASH: begin
        used = 1'b1;
        if (b == "*") begin
          if (depth_r < DMAX) depth_nxt = depth_r + DW'(1);
          mode_nxt = stok_pkg::M_BLOCK;
        end else if (b == "/") begin
          mode_nxt = stok_pkg::M_BLOCK_SLASH;
        end else begin
          mode_nxt = stok_pkg::M_BLOCK;
        end
      end
      stok_pkg::M_BLOCK: begin
        used = 1'b1;
        if (b == "*") mode_nxt = stok_pkg::M_BLOCK_STAR;
        else if (b == "/") mode_nxt = stok_pkg::M_BLOCK_SLASH;
      end
      default: mode_nxt = stok_pkg::M_IDLE;
    endcase

    if (!used && !space) begin
      if (alpha || digit || b == "+" || b == "-" || b == "*" || b == "/" || b == "=")
      begin
        mode_nxt  = alpha ? stok_pkg::M_IDENT :
                    digit ? stok_pkg::M_INT : stok_pkg::M_OPFIRST;
        first_nxt = b;
        pre_nxt   = '0;
        pre_nxt[0] = b;
        len_nxt   = 16'd1;
        so_nxt    = pos_r;
        sl_nxt    = line_r;
        sc_nxt    = col_r;
      end else begin
        t.token_kind = stok_pkg::K_INVALID;
        if (b == "{" || b == "}") t.token_kind = stok_pkg::K_BRACE;
        else if (b == "(" || b == ")") t.token_kind = stok_pkg::K_PAREN;
        else if (b == ":") t.token_kind = stok_pkg::K_COLON;
        else if (b == ";") t.token_kind = stok_pkg::K_SEMI;
        t.token_start = pos_r;
        t.token_length = 16'd1;
        t.line_number = line_r;
        t.column_number = col_r;
        bd.tok[n] = t;
        n = n + 2'd1;
      end
    end

    pos_nxt = pos_r + 32'd1;
    if (b == 8'd10) begin
      line_nxt = (line_r != 32'hFFFF_FFFF) ? line_r + 32'd1 : line_r;
      col_nxt  = 16'd1;
    end else begin
      line_nxt = line_r;
      col_nxt  = (col_r != 16'hFFFF) ? col_r + 16'd1 : col_r;
    end

    if (in_data.end_of_text) begin
      t = '0;
      t.token_start   = so_nxt;
      t.line_number   = sl_nxt;
      t.column_number = sc_nxt;
      if (mode_nxt == stok_pkg::M_IDENT) begin
        fl = 1'b1;
        fk = kw_kind(pre_nxt, len_nxt);
      end else if (mode_nxt == stok_pkg::M_INT) begin
        fl = 1'b1;
        fk = stok_pkg::K_INT;
      end else if (mode_nxt == stok_pkg::M_OPFIRST) begin
        fl = 1'b1;
        fk = stok_pkg::K_OPER;
      end
      if (fl) begin
        t.token_kind = fk;
        t.token_length = (mode_nxt == stok_pkg::M_OPFIRST) ? 16'd1 : len_nxt;
        bd.tok[n] = t;
        n = n + 2'd1;
      end
      t = '0;
      t.token_kind    = stok_pkg::K_EOF;
      t.token_start   = pos_nxt;
      t.line_number   = line_nxt;
      t.column_number = col_nxt;
      bd.tok[n] = t;
      n = n + 2'd1;
    end
    if (n != 2'd0) bd.tok[n - 2'd1].last_of_run = 1'b1;
    bd.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stok_pkg::M_IDLE;
      depth_r <= '0;
      first_r <= '0;
      pre_r   <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      line_r  <= 32'd1;
      col_r   <= 16'd1;
      so_r    <= '0;
      sl_r    <= 32'd1;
      sc_r    <= 16'd1;
    end else if (go) begin
      if (in_data.end_of_text) begin
        mode_r  <= stok_pkg::M_IDLE;
        depth_r <= '0;
        first_r <= '0;
        pre_r   <= '0;
        len_r   <= '0;
        pos_r   <= '0;
        line_r  <= 32'd1;
        col_r   <= 16'd1;
        so_r    <= '0;
        sl_r    <= 32'd1;
        sc_r    <= 16'd1;
      end else begin
        mode_r  <= mode_nxt;
        depth_r <= depth_nxt;
        first_r <= first_nxt;
        pre_r   <= pre_nxt;
        len_r   <= len_nxt;
        pos_r   <= pos_nxt;
        line_r  <= line_nxt;
        col_r   <= col_nxt;
        so_r    <= so_nxt;
        sl_r    <= sl_nxt;
        sc_r    <= sc_nxt;
      end
    end
  end

  assign bq_valid = go && bd.count != 2'd0;
  assign bq_data  = bd;

endmodule

// ----- hdl/stok_back.sv -----
// ----------------------------------------------------------------------------
// Tokenizer back end
// Queues token bundles and sends their tokens out one beat at a time.
// ----------------------------------------------------------------------------
module stok_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bq_valid,
  output logic                bq_full,
  input  stok_pkg::bundle_t   bq_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stok_pkg::out_item_t out_data
);

  localparam int DEPTH = 4;

  stok_pkg::bundle_t mem_r [DEPTH];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt, sel_r, sel_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign bq_full   = cnt_r == 3'(DEPTH);
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = mem_r[rp_r].tok[sel_r];
  assign pop       = out_valid && !out_stall && sel_r == mem_r[rp_r].count - 2'd1;

  always_comb begin
    wp_nxt  = bq_valid ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    sel_nxt = sel_r;
    if (out_valid && !out_stall) sel_nxt = pop ? 2'd0 : sel_r + 2'd1;
    cnt_nxt = cnt_r + 3'(bq_valid) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (bq_valid) mem_r[wp_r] <= bq_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      sel_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      sel_r <= sel_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- dv/source_tokenizer_nested_comments_tb.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Sends byte streams into the tokenizer and compares every token it emits
// with a token predictor kept inside this bench. A short table of streams
// runs first and random programs and noise follow. Both sides idle at random.
// ----------------------------------------------------------------------------
module source_tokenizer_nested_comments_tb;
  import stok_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KW_CHARS  = KEYWORD_CHARS_DEF;
  localparam int MAX_DEPTH = MAX_COMMENT_DEPTH_DEF;

  typedef enum logic [2:0] {
    S_IDLE, S_IDENT, S_INT, S_OPFIRST, S_LINE, S_BLOCK, S_BLOCK_STAR, S_BLOCK_SLASH
  } scan_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  source_tokenizer_nested_comments dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  scan_t       scan_state;
  logic [31:0] depth;
  logic [7:0]  first_char;
  logic [7:0]  prefix [KW_CHARS];
  logic [31:0] tok_len;
  logic [31:0] byte_pos;
  logic [31:0] cur_line;
  logic [31:0] cur_col;
  logic [31:0] tok_off, tok_line, tok_col;

  out_item_t   token_queue [$];
  int          mismatches = 0;
  bit          hold_off = 1'b0;
  bit          sending_done = 1'b0;

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == " " || b == 8'd9 || b == 8'd10 || b == 8'd11 || b == 8'd12 || b == 8'd13;
  endfunction

  function automatic logic [4:0] word_kind();
    string words [8];
    string w;
    words = '{"if", "else", "while", "fn", "var", "return", "break", "continue"};
    if (tok_len > KW_CHARS) return K_IDENT;
    w = "";
    for (int i = 0; i < tok_len; i++) w = {w, string'(prefix[i])};
    for (int k = 0; k < 8; k++) if (w == words[k]) return 5'(k);
    return K_IDENT;
  endfunction

  task automatic push_token(logic [4:0] kind, logic [31:0] start, logic [31:0] len,
                            logic [31:0] ln, logic [31:0] col);
    out_item_t t;
    t.token_kind = kind;
    t.token_start = start;
    t.token_length = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
    t.line_number = ln;
    t.column_number = (col > 32'hFFFF) ? 16'hFFFF : col[15:0];
    t.last_of_run = 1'b0;
    token_queue.push_back(t);
  endtask

  task automatic clear_scanner();
    scan_state = S_IDLE;
    depth = 0;
    first_char = 0;
    foreach (prefix[i]) prefix[i] = 0;
    tok_len = 0;
    byte_pos = 0;
    cur_line = 1;
    cur_col = 1;
    tok_off = 0;
    tok_line = 1;
    tok_col = 1;
  endtask

  task automatic open_token(scan_t s, logic [7:0] b, logic [31:0] p, logic [31:0] ln,
                            logic [31:0] col);
    scan_state = s;
    first_char = b;
    foreach (prefix[i]) prefix[i] = 0;
    prefix[0] = b;
    tok_len = 1;
    tok_off = p;
    tok_line = ln;
    tok_col = col;
  endtask

  task automatic scan_byte(in_item_t it);
    logic [7:0]  b;
    logic [31:0] p, ln, col;
    logic [4:0]  k;
    bit          taken;
    int          before_n;
    b = it.src_byte;
    p = byte_pos;
    ln = cur_line;
    col = cur_col;
    taken = 1'b0;
    before_n = token_queue.size();
    case (scan_state)
      S_IDENT: begin
        if (is_letter(b) || is_num(b)) begin
          if (tok_len < KW_CHARS) prefix[tok_len] = b;
          if (tok_len < 32'hFFFF) tok_len++;
          taken = 1'b1;
        end else begin
          push_token(word_kind(), tok_off, tok_len, tok_line, tok_col);
          scan_state = S_IDLE;
        end
      end
      S_INT: begin
        if (is_num(b)) begin
          if (tok_len < 32'hFFFF) tok_len++;
          taken = 1'b1;
        end else begin
          push_token(K_INT, tok_off, tok_len, tok_line, tok_col);
          scan_state = S_IDLE;
        end
      end
      S_OPFIRST: begin
        scan_state = S_IDLE;
        taken = 1'b1;
        if (first_char == "-" && b == ">") begin
          push_token(K_ARROW, tok_off, 2, tok_line, tok_col);
        end else if ((first_char == "+" && (b == "+" || b == "=")) ||
                     (first_char == "-" && (b == "-" || b == "=")) || b == "=") begin
          push_token(K_OPER, tok_off, 2, tok_line, tok_col);
        end else if (first_char == "/" && b == "/") begin
          scan_state = S_LINE;
        end else if (first_char == "/" && b == "*") begin
          scan_state = S_BLOCK;
          depth = 1;
        end else begin
          push_token(K_OPER, tok_off, 1, tok_line, tok_col);
          taken = 1'b0;
        end
      end
      S_LINE: begin
        if (b == 8'd10) scan_state = S_IDLE;
        taken = 1'b1;
      end
      S_BLOCK_STAR: begin
        taken = 1'b1;
        if (b == "/") begin
          if (depth > 0) depth--;
          scan_state = (depth == 0) ? S_IDLE : S_BLOCK;
        end else if (b == "*") begin
          scan_state = S_BLOCK_STAR;
        end else begin
          scan_state = S_BLOCK;
        end
      end
      S_BLOCK_SLASH: begin
        taken = 1'b1;
        if (b == "*") begin
          if (depth < MAX_DEPTH) depth++;
          scan_state = S_BLOCK;
        end else if (b == "/") begin
          scan_state = S_BLOCK_SLASH;
        end else begin
          scan_state = S_BLOCK;
        end
      end
      S_BLOCK: begin
        taken = 1'b1;
        if (b == "*") scan_state = S_BLOCK_STAR;
        else if (b == "/") scan_state = S_BLOCK_SLASH;
      end
      default: scan_state = S_IDLE;
    endcase
    if (!taken) begin
      if (is_blank(b)) begin
      end else if (is_letter(b)) begin
        open_token(S_IDENT, b, p, ln, col);
      end else if (is_num(b)) begin
        open_token(S_INT, b, p, ln, col);
      end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "=") begin
        open_token(S_OPFIRST, b, p, ln, col);
      end else begin
        k = K_INVALID;
        if (b == "{" || b == "}") k = K_BRACE;
        else if (b == "(" || b == ")") k = K_PAREN;
        else if (b == ":") k = K_COLON;
        else if (b == ";") k = K_SEMI;
        push_token(k, p, 1, ln, col);
      end
    end
    byte_pos = p + 1;
    if (b == 8'd10) begin
      if (cur_line < 32'hFFFF_FFFF) cur_line++;
      cur_col = 1;
    end else if (cur_col < 32'hFFFF) begin
      cur_col++;
    end
    if (it.end_of_text) begin
      if (scan_state == S_IDENT) push_token(word_kind(), tok_off, tok_len, tok_line, tok_col);
      else if (scan_state == S_INT) push_token(K_INT, tok_off, tok_len, tok_line, tok_col);
      else if (scan_state == S_OPFIRST) push_token(K_OPER, tok_off, 1, tok_line, tok_col);
      push_token(K_EOF, byte_pos, 0, cur_line, cur_col);
      clear_scanner();
    end
    if (token_queue.size() > before_n) token_queue[$].last_of_run = 1'b1;
  endtask

  task automatic send_byte(logic [7:0] b, logic eot);
    in_item_t it;
    it.src_byte = b;
    it.end_of_text = eot;
    if (!hold_off && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    scan_byte(it);
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
  endtask

  // Checks the last predicted token of a directed row: kind and length only.
  task automatic expect_kinds(logic [4:0] k0, logic [15:0] l0);
    if (token_queue.size() == 0 || token_queue[$].token_kind != k0 ||
        token_queue[$].token_length != l0) begin
      mismatches++;
      if (mismatches <= 10) begin
        if (token_queue.size() == 0)
          $display("table row: expected kind %0d length %0d, got no token", k0, l0);
        else
          $display("table row: expected kind %0d length %0d, got kind %0d length %0d",
                   k0, l0, token_queue[$].token_kind, token_queue[$].token_length);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (token_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token %p", out_data);
      end else begin
        e = token_queue.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("token mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 7) < 2) && !sending_done;
  end

  string directed [] = '{
    "if", "else", "while", "fn", "var", "return", "break", "continue",
    "ifx elsee", "{}():;", "a->b", "x++ y-- z+=1 w-=2 p*=q r/=s == = * / - +",
    "12ab 007", "// line\nx", "/* a /* b */ c */d", "/* open", "x /***/ y",
    "a\tb\r\nc\x0b\x0c", "@#$\x00\x80\xff", "abcdefghijk", "9"
  };

  function automatic string random_program();
    string parts [] = '{"if", "else", "while", "fn", "var", "return", "break",
      "continue", "{", "}", "(", ")", "->", ":", ";", "+", "++", "+=", "-", "--",
      "-=", "*", "*=", "/", "/=", "=", "==", "cnt", "x1", "_tmp", "42", "0",
      "/* c /* n */ */", "// note\n", " ", "\n", "\t"};
    string s;
    s = "";
    repeat ($urandom_range(2, 6)) begin
      s = {s, parts[$urandom_range(0, parts.size() - 1)]};
      if ($urandom_range(0, 1)) s = {s, " "};
    end
    return s;
  endfunction

  initial begin
    int sent;
    int cnt;
    clear_scanner();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) begin
      send_text(directed[i], 1'b1);
      if (i < 8) expect_kinds(K_EOF, 16'd0);
    end
    hold_off = 1'b1;
    fork
      begin
        repeat (40) @(posedge clk);
        hold_off = 1'b0;
      end
      send_text("a b c d e f g", 1'b0);
    join
    send_byte("\n", 1'b1);
    sent = 0;
    while (sent < 20) begin
      if ($urandom_range(0, 3) != 0) begin
        string s;
        s = random_program();
        send_text(s, 1'b0);
        sent += s.len();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        cnt = $urandom_range(1, 12);
        for (int i = 0; i < cnt; i++) send_byte(8'($urandom_range(0, 255)), i == cnt - 1);
        sent += cnt;
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
    cnt = 0;
    while (token_queue.size() != 0 && cnt < 10000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && token_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/stok_pkg.sv
hdl/stok_front.sv
hdl/stok_back.sv
hdl/source_tokenizer_nested_comments.sv
dv/source_tokenizer_nested_comments_tb.sv
